// ===== rtl/core/mlfq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlfq_pkg: shared types and constants of the feedback queue scheduler
// Widths, opcodes and status codes used by the channels and the core.
// ----------------------------------------------------------------------------
package mlfq_pkg;

  localparam int MaxTasks   = 64;
  localparam int NumLevels  = 5;
  localparam int ClockWidth = 32;
  localparam int TaskW      = 6;
  localparam int LevelW     = 3;
  localparam int CountW     = 7;
  localparam int QAddrW     = 9;   // level * 64 + position
  localparam logic [15:0] AgingReset = 16'd120;

  typedef enum logic [2:0] {
    OP_ADMIT  = 3'd0,
    OP_SETRUN = 3'd1,
    OP_SETBLK = 3'd2,
    OP_REMOVE = 3'd3,
    OP_PICK   = 3'd4,
    OP_REPORT = 3'd5,
    OP_BAD6   = 3'd6,
    OP_BAD7   = 3'd7
  } op_e;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StNone    = 2'd1;
  localparam logic [1:0] StInvalid = 2'd2;

  typedef struct packed {
    logic [2:0] opcode;
    logic [5:0] task_req;
    logic [4:0] ticks_used;
    logic       still_runnable;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [5:0] chosen_task;
    logic [2:0] chosen_level;
    logic [4:0] slice_ticks;
  } rsp_t;

  // per-slot entry of the task table: current level and last service time
  typedef struct packed {
    logic [LevelW-1:0]     level;
    logic [ClockWidth-1:0] served;
  } slot_t;

  // 2^level, saturated at 31
  function automatic logic [4:0] slice_of(input logic [LevelW-1:0] lv);
    logic [4:0] s;
    s = 5'd31;
    if (lv < 3'd5) s = 5'(1 << lv);
    return s;
  endfunction

endpackage

// ===== rtl/core/mlfq_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlfq_req_if / mlfq_rsp_if: valid-ready channels of the scheduler
// A transfer happens on a rising edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface mlfq_req_if;
  logic             valid;
  logic             ready;
  mlfq_pkg::req_t   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mlfq_rsp_if;
  logic             valid;
  logic             ready;
  mlfq_pkg::rsp_t   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/multilevel_feedback_queue_scheduler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multilevel_feedback_queue_scheduler: five-level feedback queue scheduler
// Sequencer over one queue memory, one shared clock subtract/compare unit.
// ----------------------------------------------------------------------------
//  channel  | dir | transfer when   | payload
//  req      | in  | valid && ready  | opcode, task_req, ticks_used, still_runnable
//  rsp      | out | valid && ready  | status, chosen_task, chosen_level, slice_ticks
//  cfg      | in  | cfg_we_i        | aging_limit (16 bits)
//
//  Remove and report search and shift the queue in the single-port queue
//  memory; pick runs an aging pass over the slots, each promotion adding a
//  drop and push, then scans the queue entries level by level.
//  Reset is asynchronous; no clearing pass (queue entries past counts and
//  task table entries of invalid slots are never read). One item at a time;
//  the result register waits for rsp.ready.
// ----------------------------------------------------------------------------
module multilevel_feedback_queue_scheduler (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [15:0]         cfg_wdata_i,
  mlfq_req_if.sink            req_i,
  mlfq_rsp_if.source          rsp_o
);
  import mlfq_pkg::*;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_DEC   = 5'd1;
  localparam logic [4:0] S_DFIND = 5'd2;  // drop: search
  localparam logic [4:0] S_DRD   = 5'd3;  // drop: read next
  localparam logic [4:0] S_DWR   = 5'd4;  // drop: write back shifted
  localparam logic [4:0] S_PUSH  = 5'd5;
  localparam logic [4:0] S_AGE   = 5'd6;
  localparam logic [4:0] S_SCAN  = 5'd7;
  localparam logic [4:0] S_SCHK  = 5'd8;
  localparam logic [4:0] S_DONE  = 5'd9;
  localparam logic [4:0] S_OUT   = 5'd10;
  localparam logic [4:0] S_FWAIT = 5'd11; // drop: read latency
  localparam logic [4:0] S_ACHK  = 5'd12; // aging: slot entry read back

  logic [4:0] state_q, state_d;

  // queue memory, single port, registered read
  logic [TaskW-1:0] qmem [0:NumLevels*MaxTasks-1];
  logic [QAddrW-1:0] qaddr;
  logic              qwe;
  logic [TaskW-1:0]  qwdata, qrd_q;
  always_ff @(posedge clk_i) begin
    if (qwe) qmem[qaddr] <= qwdata;
    qrd_q <= qmem[qaddr];
  end

  // task table (level, last service time), single port, registered read
  slot_t             tmem [0:MaxTasks-1];
  logic [TaskW-1:0]  taddr;
  logic              twe;
  slot_t             twdata, trd_q;
  always_ff @(posedge clk_i) begin
    if (twe) tmem[taddr] <= twdata;
    trd_q <= tmem[taddr];
  end

  logic [CountW-1:0]    cnt_q [NumLevels];
  logic [MaxTasks-1:0]  tval_q, trun_q;
  logic [ClockWidth-1:0] clk_cnt_q;
  logic [15:0]          aging_q;

  req_t                 req_q;
  rsp_t                 rsp_q;
  logic                 rsp_v_q;
  logic [TaskW:0]       idx_q;        // position / slot counter
  logic [LevelW-1:0]    lv_q;         // level being worked on
  logic [LevelW-1:0]    plv_q;        // push target level
  logic [TaskW-1:0]     tsk_q;        // task being moved
  logic                 pend_push_q;  // after drop, push
  logic                 aging_q_f;    // drop/push is part of aging

  wire [TaskW-1:0] t = req_q.task_req;
  wire [CountW-1:0] cur_cnt = cnt_q[lv_q];
  wire [TaskW-1:0] age_slot = idx_q[TaskW-1:0];

  // shared unit: waiting time compare
  logic [ClockWidth-1:0] wait_t;
  assign wait_t = clk_cnt_q - trd_q.served;
  wire aged = wait_t >= {{(ClockWidth-16){1'b0}}, aging_q};
  wire promote = tval_q[age_slot] && trun_q[age_slot] && trd_q.level != '0 && aged;

  // report: next level and advanced clock
  logic [LevelW-1:0]     rep_lv;
  logic [ClockWidth-1:0] rep_clk;
  always_comb begin
    rep_lv = trd_q.level;
    if (trd_q.level == '0 || req_q.ticks_used >= slice_of(trd_q.level))
      rep_lv = (trd_q.level < LevelW'(NumLevels-1)) ? trd_q.level + 3'd1 : trd_q.level;
  end
  assign rep_clk = clk_cnt_q + ClockWidth'(req_q.ticks_used);

  always_comb begin
    qaddr  = {lv_q, idx_q[TaskW-1:0]};
    qwe    = 1'b0;
    qwdata = qrd_q;
    unique case (state_q)
      S_DWR:  begin qaddr = {lv_q, 6'(idx_q - 7'd1)}; qwe = 1'b1; end
      S_PUSH: begin qaddr = {plv_q, cnt_q[plv_q][TaskW-1:0]}; qwe = 1'b1;
                    qwdata = tsk_q; end
      default: ;
    endcase
  end

  // task table port: prefetch on accept, update on admit/report/promotion
  always_comb begin
    taddr  = t;
    twe    = 1'b0;
    twdata = '{level: '0, served: clk_cnt_q};
    unique case (state_q)
      S_IDLE: taddr = req_i.data.task_req;
      S_DEC: begin
        if (op_e'(req_q.opcode) == OP_ADMIT && !tval_q[t]) twe = 1'b1;
        if (op_e'(req_q.opcode) == OP_REPORT && tval_q[t]) begin
          twe = 1'b1;
          twdata = '{level: rep_lv, served: rep_clk};
        end
      end
      S_AGE: taddr = age_slot;
      S_ACHK: begin
        taddr  = age_slot;
        twe    = promote;
        twdata = '{level: trd_q.level - 3'd1, served: clk_cnt_q};
      end
      default: ;
    endcase
  end

  assign req_i.ready = (state_q == S_IDLE) && !rsp_v_q;
  assign rsp_o.valid = rsp_v_q;
  assign rsp_o.data  = rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '{default: '0};
      tval_q    <= '0;
      trun_q    <= '0;
      clk_cnt_q <= '0;
      aging_q   <= AgingReset;
      rsp_v_q   <= 1'b0;
      idx_q     <= '0;
      lv_q      <= '0;
      plv_q     <= '0;
      tsk_q     <= '0;
      pend_push_q <= 1'b0;
      aging_q_f <= 1'b0;
      req_q     <= '0;
      rsp_q     <= '0;
    end else begin
      if (cfg_we_i) aging_q <= cfg_wdata_i;
      if (rsp_o.valid && rsp_o.ready) rsp_v_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (req_i.valid && req_i.ready) begin
          req_q   <= req_i.data;
          rsp_q   <= '{status: StInvalid, default: '0};
          state_q <= S_DEC;
        end
        S_DEC: begin
          state_q <= S_DONE;
          idx_q   <= '0;
          aging_q_f <= 1'b0;
          unique case (op_e'(req_q.opcode))
            OP_ADMIT: if (!tval_q[t]) begin
              tval_q[t] <= 1'b1; trun_q[t] <= 1'b0;
              plv_q <= '0; tsk_q <= t; rsp_q.status <= StOk;
              state_q <= S_PUSH;
            end
            OP_SETRUN, OP_SETBLK: if (tval_q[t]) begin
              trun_q[t] <= (op_e'(req_q.opcode) == OP_SETRUN);
              rsp_q.status <= StOk;
            end
            OP_REMOVE: if (tval_q[t]) begin
              tval_q[t] <= 1'b0; trun_q[t] <= 1'b0;
              lv_q <= trd_q.level; tsk_q <= t; pend_push_q <= 1'b0;
              rsp_q.status <= StOk; state_q <= S_DFIND;
            end
            OP_REPORT: if (tval_q[t]) begin
              clk_cnt_q <= rep_clk;
              trun_q[t] <= req_q.still_runnable;
              lv_q <= trd_q.level; plv_q <= rep_lv; tsk_q <= t; pend_push_q <= 1'b1;
              rsp_q.status <= StOk; state_q <= S_DFIND;
            end
            OP_PICK: state_q <= S_AGE;
            default: ;
          endcase
        end
        // aging pass over slots: issue the slot read
        S_AGE: begin
          if (idx_q == 7'(MaxTasks)) begin
            idx_q <= '0; lv_q <= '0; state_q <= S_SCAN;
          end else state_q <= S_ACHK;
        end
        // aging pass: check the slot entry, promote one level
        S_ACHK: begin
          if (promote) begin
            lv_q <= trd_q.level; plv_q <= trd_q.level - 3'd1; tsk_q <= age_slot;
            pend_push_q <= 1'b1; aging_q_f <= 1'b1;
            idx_q <= '0; state_q <= S_DFIND;
          end else begin
            idx_q <= idx_q + 7'd1; state_q <= S_AGE;
          end
        end
        // drop: search position of tsk_q
        S_DFIND: begin
          if (idx_q >= cur_cnt) state_q <= pend_push_q ? S_PUSH : S_DONE;
          else state_q <= S_FWAIT;
        end
        S_FWAIT: begin
          if (qrd_q == tsk_q) begin
            idx_q <= idx_q + 7'd1; state_q <= S_DRD;
          end else begin
            idx_q <= idx_q + 7'd1; state_q <= S_DFIND;
          end
        end
        // shift: read idx, write at idx-1
        S_DRD: begin
          if (idx_q >= cur_cnt) begin
            cnt_q[lv_q] <= cur_cnt - 7'd1;
            state_q <= pend_push_q ? S_PUSH : S_DONE;
          end else state_q <= S_DWR;
        end
        S_DWR: begin
          idx_q <= idx_q + 7'd1; state_q <= S_DRD;
        end
        S_PUSH: begin
          cnt_q[plv_q] <= cnt_q[plv_q] + 7'd1;
          if (aging_q_f) begin
            aging_q_f <= 1'b0;
            idx_q <= 7'(tsk_q) + 7'd1; state_q <= S_AGE;
          end else state_q <= S_DONE;
        end
        // pick scan: lowest level, queue order
        S_SCAN: begin
          if (lv_q == LevelW'(NumLevels)) begin
            rsp_q.status <= StNone; state_q <= S_DONE;
          end else if (idx_q >= cur_cnt) begin
            idx_q <= '0; lv_q <= lv_q + 3'd1;
          end else state_q <= S_SCHK;
        end
        S_SCHK: begin
          if (trun_q[qrd_q]) begin
            rsp_q <= '{status: StOk, chosen_task: qrd_q, chosen_level: lv_q,
                       slice_ticks: slice_of(lv_q)};
            state_q <= S_DONE;
          end else begin
            idx_q <= idx_q + 7'd1; state_q <= S_SCAN;
          end
        end
        S_DONE: begin rsp_v_q <= 1'b1; state_q <= S_OUT; end
        S_OUT: if (!rsp_v_q || (rsp_o.valid && rsp_o.ready)) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/mlfq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlfq_checker: port-level checks of the scheduler
// Bound to the top level.
// ----------------------------------------------------------------------------
module mlfq_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_data
);
  import mlfq_pkg::*;

  // a result stays until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("rsp hold");
  // no input taken while a result waits
  a_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !in_ready) else $error("accept while result pending");
  // accepted input is not followed by readiness next cycle
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready) else $error("ready after accept");
  // status never reserved code
  a_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> out_data[15:14] != 2'd3) else $error("bad status");
endmodule

bind multilevel_feedback_queue_scheduler mlfq_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid(req_i.valid), .in_ready(req_i.ready),
  .out_valid(rsp_o.valid), .out_ready(rsp_o.ready), .out_data(rsp_o.data));
